// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; expects a clock named clk and an active-low reset rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define GSPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GSPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gspe_pkg.sv =====
// shared types and constants of the shortest path engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gspe_pkg;

  localparam int NODE_W   = 4;
  localparam int CMD_W    = 3;
  localparam int ST_W     = 3;
  localparam int VAL_W    = 40;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;
  localparam int MAX_PATH = 16;
  localparam int PI_W     = 4;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam cmd_t CMD_ADD_NODE = 3'd0;
  localparam cmd_t CMD_RM_NODE  = 3'd1;
  localparam cmd_t CMD_ADD_EDGE = 3'd2;
  localparam cmd_t CMD_RM_EDGE  = 3'd3;
  localparam cmd_t CMD_RD_EDGE  = 3'd4;
  localparam cmd_t CMD_FIND     = 3'd5;

  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_NODE_EXISTS = 3'd1;
  localparam status_t ST_NODE_NF     = 3'd2;
  localparam status_t ST_EDGE_EXISTS = 3'd3;
  localparam status_t ST_EDGE_NF     = 3'd4;
  localparam status_t ST_NO_PATH     = 3'd5;

  typedef struct packed {
    status_t             status;
    logic [NODE_W-1:0]   path_node;
    logic [VAL_W-1:0]    value;
    logic                last;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/gspe_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module gspe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/gspe_out_buf.sv =====
// one-beat output register of the result stream
// depends on gspe_pkg
`timescale 1ns / 1ps
`default_nettype none

module gspe_out_buf
  import gspe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire rsp_t             din,
  output logic                  free,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // status[2:0], path_node[6:3], value[46:7], zero[47]
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tlast
);

  logic valid_r;
  rsp_t data_r;

  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      data_r <= din;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, data_r.value, data_r.path_node, data_r.status};
  assign out_tlast  = data_r.last;

endmodule

`default_nettype wire

// ===== rtl/graph_shortest_path_engine.sv =====
// Graph engine holding up to NODES nodes as presence bits and an adjacency ram
// (valid bit and weight per ordered node pair); commands add or remove nodes, add,
// remove or read edges, and find a shortest path by Dijkstra. After reset a
// clearing pass wipes the adjacency ram; no command is taken meanwhile. One command
// is worked at a time. A path search alternates a select scan and a relax scan over
// the distance ram per settled node, then walks the predecessors back from the
// target and puts out one beat per path node. Each ram has a single read port. A
// finished beat waits in an output register while the next command is accepted.
// depends on gspe_pkg, gspe_ram, gspe_out_buf and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module graph_shortest_path_engine
  import gspe_pkg::*;
#(
  parameter int NODES       = 16,
  parameter int WEIGHT_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // command[2:0], first_node[6:3], second_node[10:7], edge_weight[42:11], zero[47:43]
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // status[2:0], path_node[6:3], value[46:7], zero[47]
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tlast,
  input  wire logic             cfg_tvalid,
  output logic                  cfg_tready,
  // mirror_edges[0]
  input  wire logic             cfg_tdata
);

  localparam int NI_W = $clog2(NODES);
  localparam int EA_W = $clog2(NODES * NODES);
  localparam int EW   = WEIGHT_BITS + 1;
  localparam int DW   = VAL_W + NI_W;
  localparam int CW   = NI_W + 1;
  localparam int BC_W = PI_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RESP, S_EDGE_RR, S_EDGE_DEC, S_EDGE_WR2, S_RMNODE,
    S_SEL, S_RELAX, S_WALK, S_WALK_WT, S_EMIT
  } state_t;

  function automatic logic [EA_W-1:0] eaddr(input logic [NI_W-1:0] r,
                                            input logic [NI_W-1:0] c);
    eaddr = EA_W'(r) * EA_W'(NODES) + EA_W'(c);
  endfunction

  function automatic rsp_t mk_rsp(input status_t st);
    rsp_t r;
    r.status    = st;
    r.path_node = '0;
    r.value     = '0;
    r.last      = 1'b1;
    mk_rsp = r;
  endfunction

  state_t                 state_r, state_nxt;
  logic [EA_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [NODES-1:0]       present_r, present_nxt;
  logic                   mirror_r, mirror_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [NI_W-1:0]        a_r, a_nxt, b_r, b_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  rsp_t                   rsp_r, rsp_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   tog_r, tog_nxt;
  logic                   any_r, any_nxt;
  logic [NI_W-1:0]        cur_r, cur_nxt;
  logic [VAL_W-1:0]       best_r, best_nxt;
  logic [VAL_W-1:0]       cur_dist_r, cur_dist_nxt;
  logic [NODES-1:0]       reached_r, reached_nxt;
  logic [NODES-1:0]       settled_r, settled_nxt;
  logic [EW-1:0]          fwd_r, fwd_nxt;
  logic [NI_W-1:0]        buf_r [MAX_PATH];
  logic [NI_W-1:0]        buf_nxt [MAX_PATH];
  logic [BC_W-1:0]        bcnt_r, bcnt_nxt;
  logic [PI_W-1:0]        k_r, k_nxt;
  logic [NI_W-1:0]        walk_r, walk_nxt;

  logic                   e_we;
  logic [EA_W-1:0]        e_waddr, e_raddr;
  logic [EW-1:0]          e_wdata, e_rdata;
  logic                   d_we;
  logic [NI_W-1:0]        d_waddr, d_raddr;
  logic [DW-1:0]          d_wdata, d_rdata;

  logic                   out_load, ob_free;
  rsp_t                   out_rsp, emit_rsp;

  cmd_t                   in_cmd;
  logic [NODE_W-1:0]      in_a, in_b;
  logic [NI_W+NODE_W-1:0] a_ext, b_ext, pn_ext;
  logic [NI_W-1:0]        a_idx, b_idx;
  logic                   a_rng, a_ok, b_ok, in_fire;

  logic [CW-1:0]          cnt_m1;
  logic [NI_W-1:0]        j_idx, cnt_idx;
  logic [VAL_W-1:0]       rd_dist, relax_d;
  logic [NI_W-1:0]        rd_pred;
  logic                   sel_take, any_v, relax_upd;
  logic [NI_W-1:0]        cur_v;
  logic [VAL_W-1:0]       best_v;

  assign in_cmd  = in_tdata[2:0];
  assign in_a    = in_tdata[6:3];
  assign in_b    = in_tdata[10:7];
  assign a_ext   = {{NI_W{1'b0}}, in_a};
  assign b_ext   = {{NI_W{1'b0}}, in_b};
  assign a_idx   = a_ext[NI_W-1:0];
  assign b_idx   = b_ext[NI_W-1:0];
  assign a_rng   = int'(in_a) < NODES;
  assign a_ok    = a_rng && present_r[a_idx];
  assign b_ok    = (int'(in_b) < NODES) && present_r[b_idx];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;

  assign cnt_m1  = cnt_r - 1'b1;
  assign j_idx   = cnt_m1[NI_W-1:0];
  assign cnt_idx = cnt_r[NI_W-1:0];
  assign rd_dist = d_rdata[DW-1:NI_W];
  assign rd_pred = d_rdata[NI_W-1:0];

  // select scan: smallest distance among reached, unsettled nodes, lowest index wins ties
  assign sel_take = (cnt_r != '0) && present_r[j_idx] && reached_r[j_idx] &&
                    !settled_r[j_idx] && (!any_r || rd_dist < best_r);
  assign any_v    = any_r || sel_take;
  assign cur_v    = sel_take ? j_idx : cur_r;
  assign best_v   = sel_take ? rd_dist : best_r;

  assign relax_d   = cur_dist_r + {{(VAL_W-WEIGHT_BITS){1'b0}}, e_rdata[WEIGHT_BITS-1:0]};
  assign relax_upd = (cnt_r != '0) && e_rdata[EW-1] && present_r[j_idx] &&
                     !settled_r[j_idx] && (!reached_r[j_idx] || rd_dist > relax_d);

  assign pn_ext             = {{NODE_W{1'b0}}, buf_r[k_r]};
  assign emit_rsp.status    = ST_OK;
  assign emit_rsp.path_node = pn_ext[NODE_W-1:0];
  assign emit_rsp.value     = cur_dist_r;
  assign emit_rsp.last      = (k_r == '0);
  assign out_rsp            = (state_r == S_EMIT) ? emit_rsp : rsp_r;

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    present_nxt  = present_r;
    mirror_nxt   = mirror_r;
    cmd_nxt      = cmd_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    w_nxt        = w_r;
    rsp_nxt      = rsp_r;
    cnt_nxt      = cnt_r;
    tog_nxt      = tog_r;
    any_nxt      = any_r;
    cur_nxt      = cur_r;
    best_nxt     = best_r;
    cur_dist_nxt = cur_dist_r;
    reached_nxt  = reached_r;
    settled_nxt  = settled_r;
    fwd_nxt      = fwd_r;
    buf_nxt      = buf_r;
    bcnt_nxt     = bcnt_r;
    k_nxt        = k_r;
    walk_nxt     = walk_r;
    e_we         = 1'b0;
    e_waddr      = '0;
    e_wdata      = '0;
    e_raddr      = '0;
    d_we         = 1'b0;
    d_waddr      = '0;
    d_wdata      = '0;
    d_raddr      = '0;
    out_load     = 1'b0;

    if (cfg_tvalid) begin
      mirror_nxt = cfg_tdata;
    end

    case (state_r)
      S_CLEAR: begin
        e_we        = 1'b1;
        e_waddr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == EA_W'(NODES * NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        e_raddr = eaddr(a_idx, b_idx);
        if (in_fire) begin
          cmd_nxt = in_cmd;
          a_nxt   = a_idx;
          b_nxt   = b_idx;
          w_nxt   = in_tdata[11 +: WEIGHT_BITS];
          case (in_cmd)
            CMD_ADD_NODE: begin
              state_nxt = S_RESP;
              if (!a_rng) begin
                rsp_nxt = mk_rsp(ST_NODE_NF);
              end else if (present_r[a_idx]) begin
                rsp_nxt = mk_rsp(ST_NODE_EXISTS);
              end else begin
                present_nxt[a_idx] = 1'b1;
                rsp_nxt            = mk_rsp(ST_OK);
              end
            end
            CMD_RM_NODE: begin
              if (!a_ok) begin
                rsp_nxt   = mk_rsp(ST_NODE_NF);
                state_nxt = S_RESP;
              end else begin
                cnt_nxt   = '0;
                tog_nxt   = 1'b0;
                state_nxt = S_RMNODE;
              end
            end
            CMD_ADD_EDGE, CMD_RM_EDGE, CMD_RD_EDGE: begin
              if (!a_ok || !b_ok) begin
                rsp_nxt   = mk_rsp(ST_NODE_NF);
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_EDGE_RR;
              end
            end
            CMD_FIND: begin
              if (!a_ok || !b_ok) begin
                rsp_nxt   = mk_rsp(ST_NODE_NF);
                state_nxt = S_RESP;
              end else begin
                reached_nxt        = '0;
                reached_nxt[a_idx] = 1'b1;
                settled_nxt        = '0;
                d_we               = 1'b1;
                d_waddr            = a_idx;
                d_wdata            = '0;
                cnt_nxt            = '0;
                any_nxt            = 1'b0;
                state_nxt          = S_SEL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EDGE_RR: begin
        // forward entry arrives while the reverse one is read
        e_raddr   = eaddr(b_r, a_r);
        fwd_nxt   = e_rdata;
        state_nxt = S_EDGE_DEC;
      end
      S_EDGE_DEC: begin
        state_nxt = S_RESP;
        case (cmd_r)
          CMD_ADD_EDGE: begin
            if (fwd_r[EW-1]) begin
              rsp_nxt = mk_rsp(ST_EDGE_EXISTS);
            end else begin
              e_we    = 1'b1;
              e_waddr = eaddr(a_r, b_r);
              e_wdata = {1'b1, w_r};
              rsp_nxt = mk_rsp(ST_OK);
              tog_nxt = 1'b1;
              if (mirror_r && !e_rdata[EW-1]) begin
                state_nxt = S_EDGE_WR2;
              end
            end
          end
          CMD_RM_EDGE: begin
            if (!fwd_r[EW-1]) begin
              rsp_nxt = mk_rsp(ST_EDGE_NF);
            end else begin
              e_we    = 1'b1;
              e_waddr = eaddr(a_r, b_r);
              e_wdata = {1'b0, w_r};
              rsp_nxt = mk_rsp(ST_OK);
              tog_nxt = 1'b0;
              if (mirror_r) begin
                state_nxt = S_EDGE_WR2;
              end
            end
          end
          default: begin
            if (!fwd_r[EW-1]) begin
              rsp_nxt = mk_rsp(ST_EDGE_NF);
            end else begin
              rsp_nxt       = mk_rsp(ST_OK);
              rsp_nxt.value = {{(VAL_W-WEIGHT_BITS){1'b0}}, fwd_r[WEIGHT_BITS-1:0]};
            end
          end
        endcase
      end
      S_EDGE_WR2: begin
        e_we      = 1'b1;
        e_waddr   = eaddr(b_r, a_r);
        e_wdata   = {tog_r, w_r};
        state_nxt = S_RESP;
      end
      S_RMNODE: begin
        // row entry then column entry for each index
        e_we    = 1'b1;
        e_waddr = tog_r ? eaddr(cnt_idx, a_r) : eaddr(a_r, cnt_idx);
        tog_nxt = !tog_r;
        if (tog_r) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(NODES - 1)) begin
            present_nxt[a_r] = 1'b0;
            rsp_nxt          = mk_rsp(ST_OK);
            state_nxt        = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (ob_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SEL: begin
        d_raddr  = cnt_idx;
        any_nxt  = any_v;
        cur_nxt  = cur_v;
        best_nxt = best_v;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(NODES)) begin
          cur_dist_nxt = best_v;
          if (!any_v) begin
            rsp_nxt   = mk_rsp(ST_NO_PATH);
            state_nxt = S_RESP;
          end else if (cur_v == b_r) begin
            buf_nxt[0] = b_r;
            bcnt_nxt   = BC_W'(1);
            walk_nxt   = b_r;
            k_nxt      = '0;
            state_nxt  = (b_r == a_r) ? S_EMIT : S_WALK;
          end else begin
            settled_nxt[cur_v] = 1'b1;
            cnt_nxt            = '0;
            state_nxt          = S_RELAX;
          end
        end
      end
      S_RELAX: begin
        e_raddr = eaddr(cur_r, cnt_idx);
        d_raddr = cnt_idx;
        cnt_nxt = cnt_r + 1'b1;
        // write goes to the entry read last cycle, read moves on to the next one
        if (relax_upd) begin
          d_we                = 1'b1;
          d_waddr             = j_idx;
          d_wdata             = {relax_d, cur_r};
          reached_nxt[j_idx]  = 1'b1;
        end
        if (cnt_r == CW'(NODES)) begin
          cnt_nxt   = '0;
          any_nxt   = 1'b0;
          state_nxt = S_SEL;
        end
      end
      S_WALK: begin
        d_raddr   = walk_r;
        state_nxt = S_WALK_WT;
      end
      S_WALK_WT: begin
        buf_nxt[bcnt_r[PI_W-1:0]] = rd_pred;
        bcnt_nxt                  = bcnt_r + 1'b1;
        walk_nxt                  = rd_pred;
        if (rd_pred == a_r || bcnt_r == BC_W'(MAX_PATH - 1)) begin
          k_nxt     = bcnt_r[PI_W-1:0];
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_EMIT: begin
        if (ob_free) begin
          out_load = 1'b1;
          if (k_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      present_r <= '0;
      mirror_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      present_r <= present_nxt;
      mirror_r  <= mirror_nxt;
    end
    cmd_r      <= cmd_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    w_r        <= w_nxt;
    rsp_r      <= rsp_nxt;
    cnt_r      <= cnt_nxt;
    tog_r      <= tog_nxt;
    any_r      <= any_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    cur_dist_r <= cur_dist_nxt;
    reached_r  <= reached_nxt;
    settled_r  <= settled_nxt;
    fwd_r      <= fwd_nxt;
    buf_r      <= buf_nxt;
    bcnt_r     <= bcnt_nxt;
    k_r        <= k_nxt;
    walk_r     <= walk_nxt;
  end

  gspe_ram #(
    .WIDTH(EW),
    .DEPTH(NODES * NODES)
  ) u_edge_ram (
    .clk  (clk),
    .we   (e_we),
    .waddr(e_waddr),
    .wdata(e_wdata),
    .raddr(e_raddr),
    .rdata(e_rdata)
  );

  gspe_ram #(
    .WIDTH(DW),
    .DEPTH(NODES)
  ) u_dist_ram (
    .clk  (clk),
    .we   (d_we),
    .waddr(d_waddr),
    .wdata(d_wdata),
    .raddr(d_raddr),
    .rdata(d_rdata)
  );

  gspe_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .din       (out_rsp),
    .free      (ob_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  `GSPE_ASSERT(a_settled_reached, (state_r == S_RELAX) |-> ((settled_r & ~reached_r) == '0), "settled node never reached")
  `GSPE_ASSERT(a_cur_present, (state_r == S_RELAX) |-> present_r[cur_r], "relaxing from an absent node")
  `GSPE_ASSERT(a_err_last, (out_load && out_rsp.status != ST_OK) |=> (out_tvalid && out_tlast), "error beat not marked last")
  `GSPE_ASSERT(a_load_free, out_load |-> ob_free, "result loaded over a pending beat")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench for graph_shortest_path_engine: directed and random command streams
// checked against an in-bench graph model; depends on gspe_pkg and the engine rtl
`timescale 1ns / 1ps

module testbench;
  import gspe_pkg::*;

  localparam int NN = 16;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    status_t          status;
    logic [3:0]       path_node;
    logic [VAL_W-1:0] value;
    logic             last;
  } beat_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tready = 0;
  logic cfg_tvalid = 0;
  logic cfg_tdata = 0;
  wire in_tready, out_tvalid, out_tlast, cfg_tready;
  wire [OUT_W-1:0] out_tdata;

  graph_shortest_path_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // graph model
  logic        mirror_q;
  logic        present_q [NN];
  logic        edge_ok [NN*NN];
  logic [31:0] edge_w [NN*NN];
  beat_t       expected_beats[$];

  int errors = 0;
  int beats_seen = 0;
  int items_sent = 0;
  int paths_found = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit timed_out = 0;

  function automatic beat_t mk(status_t st, logic [3:0] n, logic [VAL_W-1:0] v, logic l);
    beat_t b;
    b.status = st; b.path_node = n; b.value = v; b.last = l;
    return b;
  endfunction

  task automatic search_path(input int src, input int dst);
    logic [VAL_W-1:0] dist_v [NN];
    logic             seen [NN];
    logic             done [NN];
    int               pred [NN];
    int               trail [$];
    int               cur, cnt;
    bit               any, found;
    logic [VAL_W-1:0] d;
    for (int i = 0; i < NN; i++) begin
      dist_v[i] = 0; seen[i] = 0; done[i] = 0; pred[i] = 0;
    end
    seen[src] = 1;
    found = 0;
    cur = 0;
    forever begin
      any = 0;
      for (int i = 0; i < NN; i++)
        if (present_q[i] && seen[i] && !done[i])
          if (!any || dist_v[i] < dist_v[cur]) begin
            cur = i; any = 1;
          end
      if (!any) break;
      if (cur == dst) begin
        found = 1; break;
      end
      done[cur] = 1;
      for (int i = 0; i < NN; i++) begin
        if (!edge_ok[cur*NN+i] || !present_q[i] || done[i]) continue;
        d = dist_v[cur] + VAL_W'(edge_w[cur*NN+i]);
        if (!seen[i] || dist_v[i] > d) begin
          seen[i] = 1; dist_v[i] = d; pred[i] = cur;
        end
      end
    end
    if (!found) begin
      expected_beats.push_back(mk(ST_NO_PATH, 0, 0, 1));
      return;
    end
    paths_found++;
    cur = dst;
    trail.push_front(cur);
    cnt = 1;
    while (cur != src && cnt < MAX_PATH) begin
      cur = pred[cur];
      trail.push_front(cur);
      cnt++;
    end
    foreach (trail[k])
      expected_beats.push_back(mk(ST_OK, 4'(trail[k]), dist_v[dst], k == trail.size() - 1));
  endtask

  task automatic predict_command(cmd_t c, int a, int b, logic [31:0] w);
    int fwd, rev;
    fwd = a*NN + b;
    rev = b*NN + a;
    case (c)
      CMD_ADD_NODE: begin
        if (present_q[a]) expected_beats.push_back(mk(ST_NODE_EXISTS, 0, 0, 1));
        else begin
          present_q[a] = 1;
          expected_beats.push_back(mk(ST_OK, 0, 0, 1));
        end
      end
      CMD_RM_NODE: begin
        if (!present_q[a]) expected_beats.push_back(mk(ST_NODE_NF, 0, 0, 1));
        else begin
          for (int i = 0; i < NN; i++) begin
            edge_ok[a*NN+i] = 0; edge_ok[i*NN+a] = 0;
          end
          present_q[a] = 0;
          expected_beats.push_back(mk(ST_OK, 0, 0, 1));
        end
      end
      CMD_ADD_EDGE, CMD_RM_EDGE, CMD_RD_EDGE: begin
        if (!present_q[a] || !present_q[b])
          expected_beats.push_back(mk(ST_NODE_NF, 0, 0, 1));
        else if (c == CMD_ADD_EDGE) begin
          if (edge_ok[fwd]) expected_beats.push_back(mk(ST_EDGE_EXISTS, 0, 0, 1));
          else begin
            edge_ok[fwd] = 1; edge_w[fwd] = w;
            if (mirror_q && !edge_ok[rev]) begin
              edge_ok[rev] = 1; edge_w[rev] = w;
            end
            expected_beats.push_back(mk(ST_OK, 0, 0, 1));
          end
        end else if (!edge_ok[fwd])
          expected_beats.push_back(mk(ST_EDGE_NF, 0, 0, 1));
        else if (c == CMD_RD_EDGE)
          expected_beats.push_back(mk(ST_OK, 0, VAL_W'(edge_w[fwd]), 1));
        else begin
          edge_ok[fwd] = 0;
          if (mirror_q) edge_ok[rev] = 0;
          expected_beats.push_back(mk(ST_OK, 0, 0, 1));
        end
      end
      CMD_FIND: begin
        if (!present_q[a] || !present_q[b])
          expected_beats.push_back(mk(ST_NODE_NF, 0, 0, 1));
        else search_path(a, b);
      end
      default: ;
    endcase
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;

  task automatic send_cmd(cmd_t c, int a, int b, logic [31:0] w);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
    end else if ($urandom_range(0, 3) == 0) begin
      gap = 1;
    end
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_tvalid <= 1;
    in_tdata <= {5'd0, w, 4'(b), 4'(a), c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_command(c, a, b, w);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    @(posedge clk);
    while (expected_beats.size() != 0 && !timed_out) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mirror(logic m);
    cfg_tvalid <= 1;
    cfg_tdata <= m;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 0;
    mirror_q = m;
  endtask

  // receiver stall pattern plus long hold-off
  always @(posedge clk) begin
    if (hold_off) out_tready <= 0;
    else out_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    beat_t got, exp_b;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[2:0], out_tdata[6:3], out_tdata[46:7], out_tlast};
      beats_seen++;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", got);
      end else begin
        exp_b = expected_beats.pop_front();
        if (got !== exp_b) begin
          errors++;
          if (errors <= 10)
            $display("beat mismatch: status %0d/%0d node %0d/%0d value %0d/%0d last %0b/%0b",
                     exp_b.status, got.status, exp_b.path_node, got.path_node,
                     exp_b.value, got.value, exp_b.last, got.last);
        end
      end
    end
  end

  // watchdog on cycles with no handshake; counts the clearing pass too
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_tvalid && cfg_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_cmd(CMD_ADD_NODE, 0, 0, 0);
    send_cmd(CMD_ADD_NODE, 15, 0, 0);
    send_cmd(CMD_ADD_NODE, 0, 0, 0);            // already there
    send_cmd(CMD_RM_NODE, 7, 0, 0);             // missing node
    send_cmd(CMD_ADD_NODE, 7, 0, 0);
    send_cmd(CMD_ADD_EDGE, 0, 7, 32'hFFFF_FFFF);
    send_cmd(CMD_ADD_EDGE, 7, 15, 32'hFFFF_FFFF); // sum beyond 32 bits
    send_cmd(CMD_ADD_EDGE, 0, 7, 5);            // duplicate
    send_cmd(CMD_ADD_EDGE, 0, 3, 1);            // endpoint missing
    send_cmd(CMD_RD_EDGE, 0, 7, 0);
    send_cmd(CMD_RD_EDGE, 7, 0, 0);             // missing edge
    send_cmd(CMD_FIND, 0, 15, 0);
    send_cmd(CMD_FIND, 15, 0, 0);               // unreachable
    send_cmd(CMD_FIND, 7, 7, 0);                // source is target
    send_cmd(CMD_FIND, 0, 4, 0);
    send_cmd(cmd_t'(6), 1, 2, 3);               // ignored
    send_cmd(cmd_t'(7), 15, 15, 32'hFFFF_FFFF);
    send_cmd(CMD_RM_EDGE, 0, 7, 0);
    send_cmd(CMD_RM_EDGE, 0, 7, 0);
    send_cmd(CMD_ADD_EDGE, 0, 0, 0);            // self loop, zero weight
    send_cmd(CMD_RM_NODE, 7, 0, 0);
    send_cmd(CMD_RD_EDGE, 7, 15, 0);
    wait_drained();
  endtask

  task automatic test_mirror_directed();
    write_mirror(1);
    send_cmd(CMD_ADD_NODE, 7, 0, 0);
    send_cmd(CMD_ADD_EDGE, 15, 7, 32'h8000_0001);
    send_cmd(CMD_RD_EDGE, 7, 15, 0);
    send_cmd(CMD_ADD_EDGE, 7, 0, 9);
    send_cmd(CMD_ADD_EDGE, 0, 7, 2);            // reverse already there
    send_cmd(CMD_FIND, 15, 0, 0);
    send_cmd(CMD_RM_EDGE, 7, 15, 0);
    send_cmd(CMD_RD_EDGE, 15, 7, 0);
    wait_drained();
  endtask

  // mostly graph building and searches on nodes 0 to span, now and then on any of the 16
  task automatic test_random(int count, int span);
    int r, a, b;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      a = $urandom_range(0, span);
      b = $urandom_range(0, span);
      if ($urandom_range(0, 19) == 0) begin
        a = $urandom_range(0, 15); b = $urandom_range(0, 15);
      end
      if (r < 12) send_cmd(CMD_ADD_NODE, a, b, $urandom);
      else if (r < 17) send_cmd(CMD_RM_NODE, a, b, $urandom);
      else if (r < 50) send_cmd(CMD_ADD_EDGE, a, b, rand_weight());
      else if (r < 58) send_cmd(CMD_RM_EDGE, a, b, $urandom);
      else if (r < 68) send_cmd(CMD_RD_EDGE, a, b, $urandom);
      else if (r < 97) send_cmd(CMD_FIND, a, b, $urandom);
      else send_cmd(cmd_t'($urandom_range(6, 7)), a, b, $urandom);
    end
    wait_drained();
  endtask

  // receiver holds off while commands keep coming
  task automatic test_backpressure();
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      test_random(30, 15);
    join
  endtask

  initial begin
    mirror_q = 0;
    for (int i = 0; i < NN; i++) present_q[i] = 0;
    for (int i = 0; i < NN*NN; i++) begin
      edge_ok[i] = 0; edge_w[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1;
    test_directed();
    test_mirror_directed();
    write_mirror(0);
    test_random(90, 7);
    write_mirror(1);
    test_random(80, 15);
    test_backpressure();
    write_mirror(0);
    test_random(40, 5);
    $display("covered %0d commands, %0d result beats, %0d paths found, both mirror settings",
             items_sent, beats_seen, paths_found);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d beats still expected", errors, expected_beats.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
